// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants and types for the text console writer.
package tcw_pkg;

	localparam int unsigned CELL_DEPTH = 8192;
	localparam int unsigned ADDR_W     = $clog2(CELL_DEPTH);
	localparam int unsigned CUR_W      = $clog2(CELL_DEPTH + 1);
	localparam int unsigned DIV_W      = $clog2(CUR_W);
	localparam int unsigned CELL_W     = 16;
	localparam int unsigned MAX_COLS   = (CELL_DEPTH < 128) ? CELL_DEPTH : 128;
	localparam int unsigned MAX_ROWS   = 64;

	localparam logic [7:0] CH_NL      = 8'h0a;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_CLEAR = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] REG_COLUMNS = 2'd0;
	localparam logic [1:0] REG_ROWS    = 2'd1;
	localparam logic [1:0] REG_ATTR    = 2'd2;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} ram_wr_t;

endpackage

// ===== hw/rtl/text_console_writer.sv =====
// Text console writer: screen store, cursor and command sequencer.
//
// Commands enter on start/func/char_code/cell_index and are taken at a clock
// edge with start high and busy low. Each command returns one word on
// cursor_pos/cell_char/cell_attr, marked by done for a single cycle; there is
// no back-pressure on the result side.
// A character, carriage return, newline or unused func that does not scroll
// gives done from the execute state; a cell read first passes the read-data
// state. A write that runs off the end of the screen scrolls, which walks the
// screen in the single store; a clear sweeps the screen to blank cells.
// The next command can be taken in the cycle done is shown.
// Geometry registers are written on cfg_valid/cfg_index/cfg_data (cfg_ready
// is always high). After any register write busy stays high while the row
// limit and cursor column are recomputed by a bit-serial search and divider.
// After reset the store is swept to blank cells, one cell per cycle,
// followed by the geometry pass; busy is high meanwhile.
module text_console_writer import tcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  char_code,
	input  logic [12:0] cell_index,
	output logic        done,
	output logic [12:0] cursor_pos,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_GEO,
		S_SIZE,
		S_DIV,
		S_EXEC,
		S_RDATA,
		S_SCR,
		S_FILL
	} state_t;

	state_t            state_q;
	logic [7:0]        cols_q;
	logic [6:0]        rows_q;
	logic [7:0]        attr_q;
	logic              geo_dirty_q;
	logic [7:0]        c_q;
	logic [6:0]        rlim_q;
	logic [6:0]        r_q;
	logic [2:0]        bit_q;
	logic [CUR_W-1:0]  size_q;
	logic [DIV_W-1:0]  div_bit_q;
	logic [7:0]        rem_q;
	logic [6:0]        col_q;
	logic [CUR_W-1:0]  cursor_q;
	logic [1:0]        func_q;
	logic [7:0]        char_q;
	logic [12:0]       idx_q;
	logic [CUR_W-1:0]  scr_i_q;
	logic              wr_pend_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic [CUR_W-1:0]  fill_i_q;
	logic [CUR_W-1:0]  fill_end_q;
	logic [CELL_W-1:0] fill_data_q;
	logic              item_q;
	logic              done_q;
	logic [12:0]       cursor_pos_q;
	logic [7:0]        cell_char_q;
	logic [7:0]        cell_attr_q;

	logic              cfg_wr;
	logic [CUR_W-1:0]  c_ext;
	logic              off;
	logic [CUR_W-1:0]  cur_fix;
	logic [6:0]        col_fix;
	logic [7:0]        col_inc;
	logic [CUR_W-1:0]  ncur;
	logic [6:0]        ncol;
	logic              wrap;
	logic              is_ctrl;
	logic              idx_ok;
	logic              rd_go;
	logic [6:0]        geo_t;
	logic [14:0]       geo_prod;
	logic [8:0]        div_sh;
	logic [7:0]        div_rem;
	logic [7:0]        c_clamp;
	logic [6:0]        r_clamp;
	ram_wr_t           ram_wr;
	logic              ram_rd_en;
	logic [ADDR_W-1:0] ram_rd_addr;
	logic [CELL_W-1:0] ram_rd_data;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign busy       = (state_q != S_IDLE) || geo_dirty_q;
	assign done       = done_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

	assign c_ext = CUR_W'(c_q);

	// geometry clamps
	always_comb begin
		if (cols_q == 8'd0) begin
			c_clamp = 8'd1;
		end else if (32'(cols_q) > MAX_COLS) begin
			c_clamp = 8'(MAX_COLS);
		end else begin
			c_clamp = cols_q;
		end
		if (rows_q == 7'd0) begin
			r_clamp = 7'd1;
		end else if (32'(rows_q) > MAX_ROWS) begin
			r_clamp = 7'(MAX_ROWS);
		end else begin
			r_clamp = rows_q;
		end
	end

	// row limit search: largest rows <= clamp with rows*cols <= depth
	assign geo_t    = r_q | (7'd1 << bit_q);
	assign geo_prod = 15'(geo_t) * 15'(c_q);

	// restoring step for cursor % cols
	assign div_sh  = {rem_q, cursor_q[div_bit_q]};
	assign div_rem = (div_sh >= {1'b0, c_q}) ? 8'(div_sh - {1'b0, c_q}) : div_sh[7:0];

	// cursor update for a character word
	always_comb begin
		off     = cursor_q >= size_q;
		cur_fix = off ? size_q - c_ext : cursor_q;
		col_fix = off ? 7'd0 : col_q;
		col_inc = {1'b0, col_fix} + 8'd1;
		is_ctrl = 1'b1;
		case (char_q)
			CH_NL: begin
				ncur = cur_fix - CUR_W'(col_fix) + c_ext;
				ncol = 7'd0;
			end
			CH_CR: begin
				ncur = cur_fix - CUR_W'(col_fix);
				ncol = 7'd0;
			end
			default: begin
				is_ctrl = 1'b0;
				ncur    = cur_fix + CUR_W'(1);
				ncol    = (col_inc == c_q) ? 7'd0 : col_inc[6:0];
			end
		endcase
		wrap = ncur >= size_q;
	end

	assign idx_ok = 32'(idx_q) < CELL_DEPTH;
	assign rd_go  = (scr_i_q + c_ext) < size_q;

	// store port muxing
	always_comb begin
		ram_wr      = '0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		case (state_q)
			S_FILL: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = ADDR_W'(fill_i_q);
				ram_wr.data = fill_data_q;
			end
			S_SCR: begin
				ram_wr.en   = wr_pend_s1;
				ram_wr.addr = wr_addr_s1;
				ram_wr.data = ram_rd_data;
				ram_rd_en   = rd_go;
				ram_rd_addr = ADDR_W'(scr_i_q + c_ext);
			end
			S_EXEC: begin
				ram_wr.en   = (func_q == FUNC_WRITE) && !is_ctrl;
				ram_wr.addr = ADDR_W'(cur_fix);
				ram_wr.data = {attr_q, char_q};
				ram_rd_en   = (func_q == FUNC_READ) && idx_ok;
				ram_rd_addr = ADDR_W'(idx_q);
			end
			default: begin
			end
		endcase
	end

	tcw_screen_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_FILL;
			cols_q       <= 8'd80;
			rows_q       <= 7'd25;
			attr_q       <= 8'd15;
			geo_dirty_q  <= 1'b1;
			c_q          <= 8'd1;
			rlim_q       <= 7'd1;
			r_q          <= 7'd0;
			bit_q        <= 3'd0;
			size_q       <= CUR_W'(1);
			div_bit_q    <= '0;
			rem_q        <= 8'd0;
			col_q        <= 7'd0;
			cursor_q     <= '0;
			func_q       <= 2'd0;
			char_q       <= 8'd0;
			idx_q        <= 13'd0;
			scr_i_q      <= '0;
			wr_pend_s1   <= 1'b0;
			wr_addr_s1   <= '0;
			fill_i_q     <= '0;
			fill_end_q   <= CUR_W'(CELL_DEPTH);
			fill_data_q  <= {8'h00, BLANK_CHAR};
			item_q       <= 1'b0;
			done_q       <= 1'b0;
			cursor_pos_q <= 13'd0;
			cell_char_q  <= 8'd0;
			cell_attr_q  <= 8'd0;
		end else begin
			done_q     <= 1'b0;
			wr_pend_s1 <= 1'b0;

			if (cfg_wr) begin
				geo_dirty_q <= 1'b1;
				case (cfg_index)
					REG_COLUMNS: cols_q <= cfg_data;
					REG_ROWS:    rows_q <= cfg_data[6:0];
					REG_ATTR:    attr_q <= cfg_data;
					default: begin
					end
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (geo_dirty_q) begin
						c_q     <= c_clamp;
						rlim_q  <= r_clamp;
						r_q     <= 7'd0;
						bit_q   <= 3'd6;
						state_q <= S_GEO;
					end else if (start) begin
						func_q  <= func;
						char_q  <= char_code;
						idx_q   <= cell_index;
						state_q <= S_EXEC;
					end
				end
				S_GEO: begin
					if ((geo_t <= rlim_q) && (32'(geo_prod) <= CELL_DEPTH)) begin
						r_q <= geo_t;
					end
					bit_q <= bit_q - 3'd1;
					if (cfg_wr) begin
						state_q <= S_IDLE;
					end else if (bit_q == 3'd0) begin
						state_q <= S_SIZE;
					end
				end
				S_SIZE: begin
					size_q    <= CUR_W'(15'(r_q) * 15'(c_q));
					rem_q     <= 8'd0;
					div_bit_q <= DIV_W'(CUR_W - 1);
					state_q   <= cfg_wr ? S_IDLE : S_DIV;
				end
				S_DIV: begin
					rem_q     <= div_rem;
					div_bit_q <= div_bit_q - DIV_W'(1);
					if (cfg_wr) begin
						state_q <= S_IDLE;
					end else if (div_bit_q == '0) begin
						col_q       <= div_rem[6:0];
						geo_dirty_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				S_EXEC: begin
					case (func_q)
						FUNC_WRITE: begin
							col_q <= ncol;
							if (wrap) begin
								cursor_q <= ncur - c_ext;
								scr_i_q  <= '0;
								state_q  <= S_SCR;
							end else begin
								cursor_q     <= ncur;
								done_q       <= 1'b1;
								cursor_pos_q <= 13'(ncur);
								cell_char_q  <= 8'd0;
								cell_attr_q  <= 8'd0;
								state_q      <= S_IDLE;
							end
						end
						FUNC_CLEAR: begin
							cursor_q    <= '0;
							col_q       <= 7'd0;
							fill_i_q    <= '0;
							fill_end_q  <= size_q;
							fill_data_q <= {attr_q, BLANK_CHAR};
							item_q      <= 1'b1;
							state_q     <= S_FILL;
						end
						FUNC_READ: begin
							if (idx_ok) begin
								state_q <= S_RDATA;
							end else begin
								done_q       <= 1'b1;
								cursor_pos_q <= 13'(cursor_q);
								cell_char_q  <= 8'd0;
								cell_attr_q  <= 8'd0;
								state_q      <= S_IDLE;
							end
						end
						default: begin
							done_q       <= 1'b1;
							cursor_pos_q <= 13'(cursor_q);
							cell_char_q  <= 8'd0;
							cell_attr_q  <= 8'd0;
							state_q      <= S_IDLE;
						end
					endcase
				end
				S_RDATA: begin
					done_q       <= 1'b1;
					cursor_pos_q <= 13'(cursor_q);
					cell_char_q  <= ram_rd_data[7:0];
					cell_attr_q  <= ram_rd_data[15:8];
					state_q      <= S_IDLE;
				end
				S_SCR: begin
					// read row below, write it one row up on the next cycle
					if (rd_go) begin
						scr_i_q    <= scr_i_q + CUR_W'(1);
						wr_pend_s1 <= 1'b1;
						wr_addr_s1 <= ADDR_W'(scr_i_q);
					end else begin
						fill_i_q    <= size_q - c_ext;
						fill_end_q  <= size_q;
						fill_data_q <= {attr_q, BLANK_CHAR};
						item_q      <= 1'b1;
						state_q     <= S_FILL;
					end
				end
				S_FILL: begin
					fill_i_q <= fill_i_q + CUR_W'(1);
					if (fill_i_q + CUR_W'(1) == fill_end_q) begin
						item_q  <= 1'b0;
						state_q <= S_IDLE;
						if (item_q) begin
							done_q       <= 1'b1;
							cursor_pos_q <= 13'(cursor_q);
							cell_char_q  <= 8'd0;
							cell_attr_q  <= 8'd0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result shown while sequencer not idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted without going busy");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_wr.en && ram_rd_en) |-> (ram_wr.addr != ram_rd_addr))
		else $error("store read and write hit the same cell");

	a_scroll_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCR && ram_wr.en && ram_rd_en) |-> (ram_wr.addr < ram_rd_addr))
		else $error("scroll write overtook its read");

endmodule

// ===== hw/rtl/tcw_screen_ram.sv =====
// Screen cell store: one write port, one read port with registered data.
module tcw_screen_ram import tcw_pkg::*; (
	input  logic              clk,
	input  ram_wr_t           wr,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [CELL_W-1:0] rd_data
);

	logic [CELL_W-1:0] mem [CELL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for text_console_writer: directed and random commands against a screen shadow.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	// Worst case is a scroll or clear of the full 128x64 screen per command.
	localparam int unsigned CYCLE_LIMIT  = 60_000_000;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [12:0] cursor;
		logic [7:0]  ch;
		logic [7:0]  attr;
	} console_word_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  func       = FUNC_WRITE;
	logic [7:0]  char_code  = 8'h00;
	logic [12:0] cell_index = 13'd0;
	logic        cfg_valid  = 1'b0;
	logic [1:0]  cfg_index  = REG_COLUMNS;
	logic [7:0]  cfg_data   = 8'h00;
	logic        busy;
	logic        done;
	logic [12:0] cursor_pos;
	logic [7:0]  cell_char;
	logic [7:0]  cell_attr;
	logic        cfg_ready;

	// shadow of the screen store, cursor and geometry registers
	logic [15:0]   shadow_cells [CELL_DEPTH];
	int unsigned   shadow_cursor;
	logic [7:0]    reg_cols;
	logic [6:0]    reg_rows;
	logic [7:0]    reg_attr;
	console_word_t expected_words [$];

	int unsigned error_count = 0;
	int unsigned cycle_count = 0;
	int unsigned next_gap    = 0;
	bit          start_held  = 1'b0;
	bit          no_idle     = 1'b0;

	text_console_writer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.char_code  (char_code),
		.cell_index (cell_index),
		.done       (done),
		.cursor_pos (cursor_pos),
		.cell_char  (cell_char),
		.cell_attr  (cell_attr),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("text_console_writer: mismatch");
			$finish;
		end
	end

	function automatic int unsigned view_cols();
		int unsigned c;
		c = 32'(reg_cols);
		if (c < 1) c = 1;
		if (c > MAX_COLS) c = MAX_COLS;
		return c;
	endfunction

	function automatic int unsigned view_rows(int unsigned c);
		int unsigned r;
		r = 32'(reg_rows);
		if (r < 1) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		if (r * c > CELL_DEPTH) r = CELL_DEPTH / c;
		return r;
	endfunction

	// Apply one command to the shadow and return the word it should produce.
	function automatic console_word_t predict_word(logic [1:0] f, logic [7:0] ch,
			logic [12:0] idx);
		int unsigned   c;
		int unsigned   span;
		int unsigned   i;
		console_word_t w;
		c    = view_cols();
		span = c * view_rows(c);
		w    = '0;
		case (f)
			FUNC_WRITE: begin
				// cursor left off screen by a geometry change restarts on the last row
				if (shadow_cursor >= span) shadow_cursor = span - c;
				if (ch == CH_NL) shadow_cursor = (shadow_cursor / c + 1) * c;
				else if (ch == CH_CR) shadow_cursor = (shadow_cursor / c) * c;
				else begin
					shadow_cells[ADDR_W'(shadow_cursor)] = {reg_attr, ch};
					shadow_cursor++;
				end
				if (shadow_cursor >= span) begin
					for (i = 0; i + c < span; i++)
						shadow_cells[ADDR_W'(i)] = shadow_cells[ADDR_W'(i + c)];
					for (i = span - c; i < span; i++)
						shadow_cells[ADDR_W'(i)] = {reg_attr, BLANK_CHAR};
					shadow_cursor -= c;
				end
			end
			FUNC_CLEAR: begin
				for (i = 0; i < span; i++) shadow_cells[ADDR_W'(i)] = {reg_attr, BLANK_CHAR};
				shadow_cursor = 0;
			end
			FUNC_READ: begin
				if (32'(idx) < CELL_DEPTH) begin
					w.ch   = shadow_cells[idx][7:0];
					w.attr = shadow_cells[idx][15:8];
				end
			end
			default: ;
		endcase
		w.cursor = 13'(shadow_cursor);
		return w;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] ERROR %s", $realtime, what);
		error_count++;
	endtask

	always @(posedge clk) begin
		console_word_t want;
		if (done === 1'b1) begin
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("word with none expected: cursor %0d char %02h attr %02h",
					cursor_pos, cell_char, cell_attr));
			end else begin
				want = expected_words.pop_front();
				if (cursor_pos !== want.cursor)
					report_mismatch($sformatf("cursor_pos %0d, expected %0d", cursor_pos, want.cursor));
				if (cell_char !== want.ch)
					report_mismatch($sformatf("cell_char %02h, expected %02h", cell_char, want.ch));
				if (cell_attr !== want.attr)
					report_mismatch($sformatf("cell_attr %02h, expected %02h", cell_attr, want.attr));
			end
		end
	end

	// Send one command; start stays high when the next one follows without a gap.
	task automatic issue_cmd(logic [1:0] f, logic [7:0] ch, logic [12:0] idx);
		repeat (next_gap) @(posedge clk);
		start      <= 1'b1;
		func       <= f;
		char_code  <= ch;
		cell_index <= idx;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		expected_words.push_back(predict_word(f, ch, idx));
		if ($urandom_range(0, 47) == 0) no_idle = !no_idle;
		next_gap = no_idle ? 0 : $urandom_range(0, 6);
		start_held = (next_gap == 0);
		if (!start_held) start <= 1'b0;
	endtask

	task automatic park_start();
		if (start_held) begin
			start <= 1'b0;
			start_held = 1'b0;
		end
		@(posedge clk);
	endtask

	// Register writes only go in with nothing outstanding and the block idle.
	task automatic write_reg(logic [1:0] index, logic [7:0] data);
		park_start();
		while (expected_words.size() != 0) @(posedge clk);
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		cfg_valid <= 1'b0;
		case (index)
			REG_COLUMNS: reg_cols = data;
			REG_ROWS:    reg_rows = data[6:0];
			REG_ATTR:    reg_attr = data;
			default: ;
		endcase
	endtask

	task automatic set_screen(int unsigned cols, int unsigned rows, int unsigned attr);
		write_reg(REG_COLUMNS, 8'(cols));
		write_reg(REG_ROWS, 8'(rows));
		write_reg(REG_ATTR, 8'(attr));
	endtask

	task automatic random_cmd(bit line_heavy);
		int unsigned c;
		int unsigned span;
		int unsigned pick;
		logic [1:0]  f;
		logic [7:0]  ch;
		logic [12:0] idx;
		c    = view_cols();
		span = c * view_rows(c);
		ch   = 8'($urandom_range(0, 255));
		idx  = 13'($urandom_range(0, CELL_DEPTH - 1));
		pick = $urandom_range(0, 99);
		if (pick < (line_heavy ? 70 : 55)) begin
			f    = FUNC_WRITE;
			pick = $urandom_range(0, 99);
			if (pick < (line_heavy ? 70 : 10)) ch = CH_NL;
			else if (pick < (line_heavy ? 73 : 15)) ch = CH_CR;
		end else if (pick < (line_heavy ? 70 : 60)) begin
			f = FUNC_CLEAR;
		end else if (pick < 96) begin
			f = FUNC_READ;
			// mostly aim at the visible screen and just past it
			if ($urandom_range(0, 9) < 7)
				idx = 13'($urandom_range(0,
					(span + 3 > CELL_DEPTH - 1) ? CELL_DEPTH - 1 : span + 3));
		end else begin
			f = FUNC_UNUSED;
		end
		issue_cmd(f, ch, idx);
	endtask

	task automatic random_phase(int unsigned cols, int unsigned rows, int unsigned count,
			bit line_heavy);
		set_screen(cols, rows, $urandom_range(0, 255));
		repeat (count) random_cmd(line_heavy);
	endtask

	// Blank store after reset, default geometry, every func except clear.
	task automatic test_reset_state();
		issue_cmd(FUNC_READ, 8'h00, 13'd0);
		issue_cmd(FUNC_READ, 8'hff, 13'h1fff);
		issue_cmd(FUNC_WRITE, 8'h41, 13'd0);
		issue_cmd(FUNC_WRITE, 8'h00, 13'd0);
		issue_cmd(FUNC_WRITE, 8'hff, 13'd0);
		issue_cmd(FUNC_WRITE, CH_NL, 13'd0);
		issue_cmd(FUNC_WRITE, CH_CR, 13'd0);
		issue_cmd(FUNC_UNUSED, 8'hff, 13'h1fff);
		issue_cmd(FUNC_READ, 8'h00, 13'd0);
	endtask

	// Zero geometry clamps to a single cell; oversized clamps to 128x64.
	task automatic test_size_extremes();
		set_screen(0, 0, 8'hff);
		issue_cmd(FUNC_WRITE, 8'h78, 13'd0);
		issue_cmd(FUNC_READ, 8'h00, 13'd0);
		issue_cmd(FUNC_WRITE, CH_NL, 13'd0);
		set_screen(255, 127, 8'h00);
		issue_cmd(FUNC_CLEAR, 8'h00, 13'd0);
		issue_cmd(FUNC_WRITE, 8'h7e, 13'd0);
		issue_cmd(FUNC_READ, 8'h00, 13'd0);
		issue_cmd(FUNC_READ, 8'h00, 13'h1fff);
	endtask

	// Shrinking the screen under the cursor.
	task automatic test_offscreen_cursor();
		set_screen(1, 1, 8'h3c);
		issue_cmd(FUNC_WRITE, CH_CR, 13'd0);
		issue_cmd(FUNC_UNUSED, 8'h00, 13'd0);
	endtask

	// Clear must leave cells past rows*columns alone.
	task automatic test_cells_beyond_screen();
		set_screen(3, 2, 8'h5a);
		issue_cmd(FUNC_CLEAR, 8'h00, 13'd0);
		issue_cmd(FUNC_READ, 8'h00, 13'd5);
		issue_cmd(FUNC_READ, 8'h00, 13'd6);
		issue_cmd(FUNC_WRITE, 8'h71, 13'd0);
		issue_cmd(FUNC_READ, 8'h00, 13'd0);
	endtask

	task automatic test_random_traffic();
		random_phase(80, 25, 150, 1'b0);
		random_phase($urandom_range(1, 8), $urandom_range(1, 4), 200, 1'b0);
		random_phase(1, $urandom_range(1, 64), 150, 1'b0);
		random_phase($urandom_range(100, 255), $urandom_range(1, 2), 150, 1'b0);
		// full screen, newline heavy so it runs off the bottom
		random_phase($urandom_range(128, 255), $urandom_range(64, 127), 160, 1'b1);
		random_phase($urandom_range(0, 20), $urandom_range(0, 10), 180, 1'b0);
		random_phase($urandom_range(1, 40), $urandom_range(1, 12), 180, 1'b0);
		random_phase($urandom_range(0, 255), $urandom_range(0, 3), 180, 1'b0);
	endtask

	initial begin
		int unsigned k;
		for (k = 0; k < CELL_DEPTH; k++) shadow_cells[ADDR_W'(k)] = {8'h00, BLANK_CHAR};
		shadow_cursor = 0;
		reg_cols      = 8'd80;
		reg_rows      = 7'd25;
		reg_attr      = 8'd15;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_size_extremes();
		test_offscreen_cursor();
		test_cells_beyond_screen();
		test_random_traffic();

		park_start();
		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) $display("text_console_writer: match");
		else $display("text_console_writer: mismatch");
		$finish;
	end

endmodule
